// ----- hdl/hbq_pkg.sv -----
`default_nettype none

package hbq_pkg;

    localparam int STATUS_WIDTH = 2;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_UP_RD,
        S_UP_CMP,
        S_REM_LD,
        S_DN_RD,
        S_DN_CMP,
        S_FIN
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic    cap;
        logic    ins_start;
        logic    rd_parent;
        logic    up_step;
        logic    place;
        logic    rd_rem;
        logic    rem_load;
        logic    rd_child;
        logic    dn_step;
        logic    set_status;
        t_status status_code;
        logic    finish;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic act_remove;
        logic full;
        logic empty;
        logic last;
        logic pos_zero;
        logic up_less;
        logic left_out;
        logic dn_swap;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- hdl/hbq_if.sv -----
`default_nettype none

interface hbq_in_if #(
    parameter int PRIORITY_WIDTH = 16,
    parameter int PAYLOAD_WIDTH  = 32
);
    logic                             valid;
    logic                             ready;
    logic                             action;
    logic signed [PRIORITY_WIDTH-1:0] priority_in;
    logic        [PAYLOAD_WIDTH-1:0]  payload_in;

    modport source (output valid, action, priority_in, payload_in, input ready);
    modport sink   (input valid, action, priority_in, payload_in, output ready);
endinterface

interface hbq_out_if #(
    parameter int PRIORITY_WIDTH = 16,
    parameter int PAYLOAD_WIDTH  = 32,
    parameter int COUNT_WIDTH    = 7
);
    logic                             valid;
    logic                             ready;
    logic [1:0]                       status;
    logic signed [PRIORITY_WIDTH-1:0] priority_out;
    logic        [PAYLOAD_WIDTH-1:0]  payload_out;
    logic        [COUNT_WIDTH-1:0]    entry_total;
    logic                             now_empty;

    modport source (output valid, status, priority_out, payload_out, entry_total, now_empty,
                    input ready);
    modport sink   (input valid, status, priority_out, payload_out, entry_total, now_empty,
                    output ready);
endinterface

`default_nettype wire

// ----- hdl/binary_min_heap_queue.sv -----
// Binary min-heap priority queue.
// i_in (sink): one word per operation. action 0 inserts priority_in/payload_in,
//   action 1 removes the entry with the smallest signed priority.
// o_out (source): one result word per operation, in order: status (ok, remove
//   on empty, insert on full), the removed priority and payload (zero unless
//   a remove succeeded), the entry count after the operation and an empty flag.
// One operation is in flight at a time; i_in.ready is high while the
// controller is idle. An insert reads the parent and then compares and writes
// back at each level it climbs, and places the entry without a compare once it
// reaches the root; a remove loads the root and last entry, then at each level
// reads both children (two read ports) and compares and writes back, until it
// reaches the leaves or a compare stops it. A rejected operation and the
// removal of the last entry go straight to the result. The worst case is an
// insert that climbs to the root. The next word is accepted only once the
// result has loaded into the output register and the controller is idle again.
// If o_out.ready stays low the following result holds in the controller until
// the output register frees up.
// Reset (synchronous, active low) empties the heap and drops any pending
// result; heap memory is not cleared.
`default_nettype none

module binary_min_heap_queue
    import hbq_pkg::*;
#(
    parameter int HEAP_DEPTH     = 64,
    parameter int PAYLOAD_WIDTH  = 32,
    parameter int PRIORITY_WIDTH = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    hbq_in_if.sink    i_in,
    hbq_out_if.source o_out
);

    localparam int COUNT_WIDTH = $clog2(HEAP_DEPTH + 1);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;
    t_status  w_status;

    hbq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    hbq_datapath #(
        .HEAP_DEPTH     (HEAP_DEPTH),
        .PAYLOAD_WIDTH  (PAYLOAD_WIDTH),
        .PRIORITY_WIDTH (PRIORITY_WIDTH),
        .COUNT_WIDTH    (COUNT_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_action      (i_in.action),
        .i_priority    (i_in.priority_in),
        .i_payload     (i_in.payload_in),
        .o_valid       (o_out.valid),
        .i_ready       (o_out.ready),
        .o_status      (w_status),
        .o_priority    (o_out.priority_out),
        .o_payload     (o_out.payload_out),
        .o_entry_total (o_out.entry_total),
        .o_now_empty   (o_out.now_empty)
    );

    assign i_in.ready   = w_in_ready;
    assign o_out.status = w_status;

endmodule

`default_nettype wire

// ----- hdl/hbq_ctrl.sv -----
`default_nettype none

module hbq_ctrl
    import hbq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!i_stat.act_remove) begin
                    if (i_stat.full) begin
                        o_cmd.set_status  = 1'b1;
                        o_cmd.status_code = ST_FULL;
                        n_state           = S_FIN;
                    end else begin
                        o_cmd.ins_start = 1'b1;
                        n_state         = S_UP_RD;
                    end
                end else if (i_stat.empty) begin
                    o_cmd.set_status  = 1'b1;
                    o_cmd.status_code = ST_EMPTY;
                    n_state           = S_FIN;
                end else begin
                    o_cmd.rd_rem = 1'b1;
                    n_state      = S_REM_LD;
                end
            end
            S_UP_RD: begin
                if (i_stat.pos_zero) begin
                    o_cmd.place = 1'b1;
                    n_state     = S_FIN;
                end else begin
                    o_cmd.rd_parent = 1'b1;
                    n_state         = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_stat.up_less) begin
                    o_cmd.up_step = 1'b1;
                    n_state       = S_UP_RD;
                end else begin
                    o_cmd.place = 1'b1;
                    n_state     = S_FIN;
                end
            end
            S_REM_LD: begin
                o_cmd.rem_load = 1'b1;
                n_state        = i_stat.last ? S_FIN : S_DN_RD;
            end
            S_DN_RD: begin
                if (i_stat.left_out) begin
                    o_cmd.place = 1'b1;
                    n_state     = S_FIN;
                end else begin
                    o_cmd.rd_child = 1'b1;
                    n_state        = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                if (i_stat.dn_swap) begin
                    o_cmd.dn_step = 1'b1;
                    n_state       = S_DN_RD;
                end else begin
                    o_cmd.place = 1'b1;
                    n_state     = S_FIN;
                end
            end
            S_FIN: begin
                // hold the result until the output register is free
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DECODE))
        else $error("accepted word not decoded");

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_stat.out_free)
        else $error("result loaded into busy output register");

    a_full_no_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECODE && !i_stat.act_remove && i_stat.full) |=> (r_state == S_FIN))
        else $error("insert started on full heap");

endmodule

`default_nettype wire

// ----- hdl/hbq_datapath.sv -----
`default_nettype none

module hbq_datapath
    import hbq_pkg::*;
#(
    parameter int HEAP_DEPTH     = 64,
    parameter int PAYLOAD_WIDTH  = 32,
    parameter int PRIORITY_WIDTH = 16,
    parameter int COUNT_WIDTH    = $clog2(HEAP_DEPTH + 1)
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire t_dp_cmd                          i_cmd,
    output t_dp_stat                              o_stat,
    input  wire logic                             i_action,
    input  wire logic signed [PRIORITY_WIDTH-1:0] i_priority,
    input  wire logic        [PAYLOAD_WIDTH-1:0]  i_payload,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output t_status                               o_status,
    output logic signed [PRIORITY_WIDTH-1:0]      o_priority,
    output logic        [PAYLOAD_WIDTH-1:0]       o_payload,
    output logic        [COUNT_WIDTH-1:0]         o_entry_total,
    output logic                                  o_now_empty
);

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int XW = AW + 2;
    localparam int EW = PRIORITY_WIDTH + PAYLOAD_WIDTH;

    logic [EW-1:0] r_mem [HEAP_DEPTH];
    logic [EW-1:0] r_rd_a, r_rd_b;

    logic                             r_action;
    logic signed [PRIORITY_WIDTH-1:0] r_mov_prio;
    logic        [PAYLOAD_WIDTH-1:0]  r_mov_pay;
    logic        [AW-1:0]             r_pos;
    logic        [AW-1:0]             r_ca, r_cb;
    logic        [COUNT_WIDTH-1:0]    r_count;
    t_status                          r_status;
    logic signed [PRIORITY_WIDTH-1:0] r_res_prio;
    logic        [PAYLOAD_WIDTH-1:0]  r_res_pay;
    logic                             r_out_valid;
    t_status                          r_out_status;
    logic signed [PRIORITY_WIDTH-1:0] r_out_prio;
    logic        [PAYLOAD_WIDTH-1:0]  r_out_pay;
    logic        [COUNT_WIDTH-1:0]    r_out_total;
    logic                             r_out_empty;

    logic [XW-1:0] w_cnt_x, w_left, w_right, w_rsel;
    logic [AW-1:0] w_parent, w_last, w_ra, w_rb, w_wa, w_pick_addr;
    logic          w_re, w_we;
    logic [EW-1:0] w_wd, w_pick;
    logic signed [PRIORITY_WIDTH-1:0] w_a_prio, w_b_prio, w_pick_prio;

    assign w_cnt_x  = XW'(r_count);
    assign w_left   = XW'({r_pos, 1'b1});
    assign w_right  = w_left + XW'(1);
    // missing right child reads as the left one
    assign w_rsel   = (w_right >= w_cnt_x) ? w_left : w_right;
    assign w_parent = (r_pos - AW'(1)) >> 1;
    assign w_last   = AW'(r_count - COUNT_WIDTH'(1));

    assign w_a_prio = r_rd_a[EW-1:PAYLOAD_WIDTH];
    assign w_b_prio = r_rd_b[EW-1:PAYLOAD_WIDTH];
    // equal children: right wins
    assign w_pick      = (w_a_prio < w_b_prio) ? r_rd_a : r_rd_b;
    assign w_pick_addr = (w_a_prio < w_b_prio) ? r_ca : r_cb;
    assign w_pick_prio = w_pick[EW-1:PAYLOAD_WIDTH];

    always_comb begin
        w_ra = w_left[AW-1:0];
        w_rb = w_rsel[AW-1:0];
        if (i_cmd.rd_parent) begin
            w_ra = w_parent;
        end else if (i_cmd.rd_rem) begin
            w_ra = '0;
            w_rb = w_last;
        end
    end

    assign w_re = i_cmd.rd_parent | i_cmd.rd_rem | i_cmd.rd_child;
    assign w_we = i_cmd.place | i_cmd.up_step | i_cmd.dn_step;
    assign w_wa = r_pos;

    always_comb begin
        priority if (i_cmd.place) begin
            w_wd = {r_mov_prio, r_mov_pay};
        end else if (i_cmd.up_step) begin
            w_wd = r_rd_a;
        end else begin
            w_wd = w_pick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_re) begin
            r_rd_a <= r_mem[w_ra];
            r_rd_b <= r_mem[w_rb];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_child) begin
            r_ca <= w_left[AW-1:0];
            r_cb <= w_rsel[AW-1:0];
        end
        if (i_cmd.cap) begin
            r_action   <= i_action;
            r_mov_prio <= i_priority;
            r_mov_pay  <= i_payload;
            r_res_prio <= '0;
            r_res_pay  <= '0;
            r_status   <= ST_OK;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status_code;
        end
        if (i_cmd.ins_start) begin
            r_pos <= r_count[AW-1:0];
        end
        if (i_cmd.up_step) begin
            r_pos <= w_parent;
        end
        if (i_cmd.dn_step) begin
            r_pos <= w_pick_addr;
        end
        if (i_cmd.rem_load) begin
            r_res_prio <= w_a_prio;
            r_res_pay  <= r_rd_a[PAYLOAD_WIDTH-1:0];
            r_mov_prio <= w_b_prio;
            r_mov_pay  <= r_rd_b[PAYLOAD_WIDTH-1:0];
            r_pos      <= '0;
        end
        if (i_cmd.finish) begin
            r_out_status <= r_status;
            r_out_prio   <= r_res_prio;
            r_out_pay    <= r_res_pay;
            r_out_total  <= r_count;
            r_out_empty  <= (r_count == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.ins_start) begin
                r_count <= r_count + COUNT_WIDTH'(1);
            end else if (i_cmd.rem_load) begin
                r_count <= r_count - COUNT_WIDTH'(1);
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.act_remove = (r_action == ACT_REMOVE);
    assign o_stat.full       = (r_count == COUNT_WIDTH'(HEAP_DEPTH));
    assign o_stat.empty      = (r_count == '0);
    assign o_stat.last       = (r_count == COUNT_WIDTH'(1));
    assign o_stat.pos_zero   = (r_pos == '0);
    assign o_stat.up_less    = (r_mov_prio < w_a_prio);
    assign o_stat.left_out   = (w_left >= w_cnt_x);
    assign o_stat.dn_swap    = (r_mov_prio > w_pick_prio);
    assign o_stat.out_free   = !r_out_valid || i_ready;

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_priority    = r_out_prio;
    assign o_payload     = r_out_pay;
    assign o_entry_total = r_out_total;
    assign o_now_empty   = r_out_empty;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_WIDTH'(HEAP_DEPTH))
        else $error("entry count beyond depth");

    a_write_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (XW'(r_pos) < w_cnt_x))
        else $error("heap write outside held entries");

    a_full_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (o_entry_total == COUNT_WIDTH'(HEAP_DEPTH)))
        else $error("full status with heap not full");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_now_empty == (o_entry_total == '0)))
        else $error("empty flag disagrees with entry total");

endmodule

`default_nettype wire

// ----- sim/binary_min_heap_queue_tb.sv -----
`timescale 1ns / 1ps

module binary_min_heap_queue_tb;
    import hbq_pkg::*;

    localparam int HEAP_DEPTH = 64;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 20;

    typedef struct packed {
        t_status     status;
        logic [15:0] prio;
        logic [31:0] payload;
        logic [6:0]  total;
        logic        empty;
    } heap_result_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hbq_in_if  #(.PRIORITY_WIDTH(16), .PAYLOAD_WIDTH(32)) in_if ();
    hbq_out_if #(.PRIORITY_WIDTH(16), .PAYLOAD_WIDTH(32), .COUNT_WIDTH(7)) out_if ();

    binary_min_heap_queue #(
        .HEAP_DEPTH     (HEAP_DEPTH),
        .PAYLOAD_WIDTH  (32),
        .PRIORITY_WIDTH (16)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow heap
    logic signed [15:0] shadow_prio [0:HEAP_DEPTH-1];
    logic [31:0]        shadow_payload [0:HEAP_DEPTH-1];
    int                 shadow_count = 0;

    heap_result_t pending_results [$];
    int mismatch_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // receiver hold-off request: token toggles, receiver counts the cycles
    logic hold_token = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;

    function automatic void swap_entries(input int a, input int b);
        logic signed [15:0] p;
        logic [31:0]        d;
        p = shadow_prio[a];
        shadow_prio[a] = shadow_prio[b];
        shadow_prio[b] = p;
        d = shadow_payload[a];
        shadow_payload[a] = shadow_payload[b];
        shadow_payload[b] = d;
    endfunction

    function automatic heap_result_t heap_apply(input logic act, input logic signed [15:0] prio,
                                                input logic [31:0] data);
        heap_result_t res;
        int pos, up, l, r, pick;
        bit done;
        res = '0;
        res.status = ST_OK;
        done = 1'b0;
        if (act == ACT_INSERT) begin
            if (shadow_count >= HEAP_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                pos = shadow_count;
                shadow_prio[pos] = prio;
                shadow_payload[pos] = data;
                shadow_count++;
                // moves up only while strictly smaller than its parent
                while (pos > 0 && !done) begin
                    up = (pos - 1) / 2;
                    if (shadow_prio[pos] < shadow_prio[up]) begin
                        swap_entries(pos, up);
                        pos = up;
                    end else begin
                        done = 1'b1;
                    end
                end
            end
        end else begin
            if (shadow_count == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.prio = shadow_prio[0];
                res.payload = shadow_payload[0];
                shadow_count--;
                if (shadow_count > 0) begin
                    shadow_prio[0] = shadow_prio[shadow_count];
                    shadow_payload[0] = shadow_payload[shadow_count];
                    pos = 0;
                    while (!done) begin
                        l = 2 * pos + 1;
                        r = 2 * pos + 2;
                        if (l >= shadow_count) begin
                            done = 1'b1;
                        end else begin
                            if (r >= shadow_count)
                                r = l;
                            // equal children pick the right one
                            pick = (shadow_prio[l] < shadow_prio[r]) ? l : r;
                            if (shadow_prio[pos] > shadow_prio[pick]) begin
                                swap_entries(pos, pick);
                                pos = pick;
                            end else begin
                                done = 1'b1;
                            end
                        end
                    end
                end
            end
        end
        res.total = shadow_count[6:0];
        res.empty = (shadow_count == 0);
        return res;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Called at a rising edge; returns at the edge that takes the word.
    task automatic send_word(input logic act, input logic signed [15:0] prio,
                             input logic [31:0] data);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.action      <= act;
        in_if.priority_in <= prio;
        in_if.payload_in  <= data;
        @(negedge i_clk);
        while (!in_if.ready)
            @(negedge i_clk);
        pending_results.push_back(heap_apply(act, prio, data));
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] pick_priority();
        logic signed [15:0] p;
        case ($urandom_range(0, 3))
            0: p = 16'($urandom_range(0, 6) - 3);   // dense range, lots of ties
            1: begin
                case ($urandom_range(0, 3))
                    0: p = 16'h7FFF;
                    1: p = 16'h8000;
                    2: p = 16'h0000;
                    default: p = 16'hFFFF;
                endcase
            end
            default: p = 16'($urandom);
        endcase
        return p;
    endfunction

    task automatic test_directed();
        send_idle_pct = 19;
        recv_idle_pct = 81;
        send_word(ACT_REMOVE, 16'h1234, 32'hDEAD_BEEF);   // empty heap
        send_word(ACT_INSERT, 16'h7FFF, 32'hFFFF_FFFF);
        send_word(ACT_INSERT, 16'h8000, 32'h0000_0000);
        send_word(ACT_INSERT, 16'h0000, 32'h0000_0001);
        send_word(ACT_INSERT, 16'hFFFF, 32'h0000_0002);
        repeat (5)
            send_word(ACT_REMOVE, 16'h0000, 32'h0000_0000);
        // equal children after a remove, and a tie against the parent on insert
        send_word(ACT_INSERT, 16'd0, 32'h0000_00A0);
        send_word(ACT_INSERT, 16'd2, 32'h0000_00A1);
        send_word(ACT_INSERT, 16'd2, 32'h0000_00A2);
        send_word(ACT_INSERT, 16'd9, 32'h0000_00A3);
        send_word(ACT_INSERT, 16'd2, 32'h0000_00A4);
        repeat (6)
            send_word(ACT_REMOVE, 16'hFFFF, 32'hFFFF_FFFF);
        wait_drained();
    endtask

    task automatic test_fill_and_drain();
        send_idle_pct = 19;
        recv_idle_pct = 81;
        repeat (HEAP_DEPTH + 2)
            send_word(ACT_INSERT, pick_priority(), $urandom);
        repeat (HEAP_DEPTH + 1)
            send_word(ACT_REMOVE, pick_priority(), $urandom);
        wait_drained();
    endtask

    task automatic test_random_mix(input int count, input int send_pct, input int recv_pct);
        int  i, ins_pct;
        logic act;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (i = 0; i < count; i++) begin
            // drift the fill level up and down in stretches
            case ((i / 32) % 3)
                0: ins_pct = 75;
                1: ins_pct = 30;
                default: ins_pct = 55;
            endcase
            act = ($urandom_range(0, 99) < ins_pct) ? ACT_INSERT : ACT_REMOVE;
            send_word(act, pick_priority(), $urandom);
        end
    endtask

    task automatic test_long_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_token <= ~hold_token;
        repeat (40)
            send_word(($urandom_range(0, 99) < 60) ? ACT_INSERT : ACT_REMOVE,
                      pick_priority(), $urandom);
        wait_drained();
    endtask

    // receiver: random ready, or a long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen    <= hold_token;
            hold_left    <= HOLD_CYCLES;
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // a word is taken at the next edge when valid and ready are both high now
    always @(negedge i_clk) begin : result_check
        heap_result_t want;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word, status %0d, entry_total %0d",
                         $time, out_if.status, out_if.entry_total);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("status", want.status, out_if.status);
                compare_field("priority_out", want.prio, $unsigned(out_if.priority_out));
                compare_field("payload_out", want.payload, out_if.payload_out);
                compare_field("entry_total", want.total, out_if.entry_total);
                compare_field("now_empty", want.empty, out_if.now_empty);
            end
        end
    end

    initial begin
        i_rst_n           <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.action      <= ACT_INSERT;
        in_if.priority_in <= '0;
        in_if.payload_in  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_fill_and_drain();
        test_random_mix(170, 19, 81);
        test_random_mix(170, 81, 19);
        test_long_stall();
        test_random_mix(170, 0, 0);

        recv_idle_pct = 0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/hbq_pkg.sv
hdl/hbq_if.sv
hdl/hbq_ctrl.sv
hdl/hbq_datapath.sv
hdl/binary_min_heap_queue.sv
sim/binary_min_heap_queue_tb.sv
